>>> rtl/ettv_pkg.sv
package ettv_pkg;

    // Field widths.
    localparam int ANGLE_BITS   = 12;
    localparam int ANGLE_COUNTS = 4096;
    localparam int STAMP_W      = 24;
    localparam int PERIOD_W     = 25;
    localparam int THR_W        = 12;
    localparam int POS_W        = 28;
    localparam int ROT_W        = POS_W - ANGLE_BITS;
    localparam int VEL_W        = 32;

    // Stream word layout.
    localparam int S_FIELDS_W   = ANGLE_BITS + STAMP_W;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W   = POS_W + ROT_W + VEL_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = PERIOD_W;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 1'd1;

    localparam int RST_COUNTER_PERIOD = 480000;
    localparam int RST_WRAP_THRESHOLD = 3276;
    localparam int TICKS_DIV          = 1000;

    // Internal arithmetic widths.
    localparam int ELAPSED_W = PERIOD_W + 2;       // signed, holds period + stamp - last
    localparam int DTMS_W    = ELAPSED_W - 1;      // positive elapsed over at least one tick
    localparam int TPM_W     = 16;                 // floor((2^25 - 1) / 1000) fits
    localparam int DVMAG_W   = POS_W;              // |dv| of two 28-bit positions
    localparam int NUM_W     = DVMAG_W + 10;       // |dv| * 1000
    localparam int WIDE_W    = NUM_W + 4;          // |dv| * 10000

    localparam int RST_TPM = RST_COUNTER_PERIOD / TICKS_DIV;

    // Shared bit-serial divider.
    localparam int DIV_N  = NUM_W;
    localparam int DIV_D  = DTMS_W;
    localparam int DIV_SW = $clog2(DIV_N + 1);

    localparam int TURN_BITS_DEF = 16;

    typedef struct packed {
        logic               start;
        logic [DIV_N-1:0]   dividend;   // left aligned to the number of steps
        logic [DIV_D-1:0]   divisor;
        logic [DIV_SW-1:0]  steps;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_N-1:0]   quotient;
    } div_rsp_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [ROT_W-1:0]   rotations;
        logic               dv_neg;
        logic [DVMAG_W-1:0] dv_mag;
    } turn_res_t;

endpackage

>>> rtl/encoder_turn_tracker_velocity.sv
// Channel   Direction  Word (low bit first)                         Handshake
// s_        in         raw_angle[11:0], timestamp[23:0], pad to 40  s_tvalid/s_tready
// m_        out        position[27:0], rotations[15:0],             m_tvalid/m_tready
//                      velocity[31:0], pad to 80
// cfg_      in         cfg_index (0 counter_period, 1 wrap_threshold) cfg_valid/cfg_ready
//
// A word with a whole millisecond elapsed goes through two divisions before its result
// is loaded: a 26-bit quotient for the milliseconds and a 38-bit one for the velocity.
// Under one millisecond the velocity division is skipped; with no positive elapsed
// time both are skipped. The next word is taken once the result has been loaded.
// A counter_period write leads to a 25-bit division; words wait until it ends.
// Reset is synchronous, active low, and restores the register defaults. A stalled
// result sits in the output register while the next word is worked on.
module encoder_turn_tracker_velocity #(
    parameter int TURN_BITS = ettv_pkg::TURN_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // raw_angle[11:0], timestamp[35:12], zeros above
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ettv_pkg::S_TDATA_W-1:0]     s_tdata,
    // position[27:0], rotations[43:28], velocity[75:44], zeros above
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ettv_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ettv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ettv_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AB  = ettv_pkg::ANGLE_BITS;
    localparam int SW  = ettv_pkg::STAMP_W;
    localparam int PW  = ettv_pkg::PERIOD_W;
    localparam int EW  = ettv_pkg::ELAPSED_W;
    localparam int DW  = ettv_pkg::DTMS_W;
    localparam int TW  = ettv_pkg::TPM_W;
    localparam int NW  = ettv_pkg::NUM_W;
    localparam int WW  = ettv_pkg::WIDE_W;
    localparam int VW  = ettv_pkg::VEL_W;
    localparam int N   = ettv_pkg::DIV_N;
    localparam int D   = ettv_pkg::DIV_D;
    localparam int STW = ettv_pkg::DIV_SW;

    localparam logic [WW-1:0] POS_LIMIT = WW'((64'd1 << (VW - 1)) - 64'd1);
    localparam logic [WW-1:0] NEG_LIMIT = WW'(64'd1 << (VW - 1));
    localparam logic [VW-1:0] VEL_MAX   = {1'b0, {(VW - 1){1'b1}}};
    localparam logic [VW-1:0] VEL_MIN   = {1'b1, {(VW - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_TPM,
        S_DT,
        S_DT_WAIT,
        S_MUL,
        S_VEL,
        S_VEL_WAIT,
        S_FIN,
        S_OUT
    } state_t;

    state_t                           state_reg;
    logic [PW-1:0]                    period_reg;
    logic [ettv_pkg::THR_W-1:0]       thr_reg;
    logic [TW-1:0]                    tpm_reg;
    logic                             tpm_stale_reg;
    logic [SW-1:0]                    last_stamp_reg;
    logic [EW-1:0]                    elapsed_reg;
    logic [DW-1:0]                    dtms_reg;
    logic [NW-1:0]                    num_reg;
    logic [VW-1:0]                    vel_reg;
    logic                             m_tvalid_reg;
    logic [ettv_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    ettv_pkg::div_req_t               div_req_reg;

    ettv_pkg::div_rsp_t               div_rsp;
    ettv_pkg::turn_res_t              turn_res;

    logic                             accept;
    logic [AB-1:0]                    sample_angle;
    logic [SW-1:0]                    in_stamp;
    logic [EW-1:0]                    elapsed_next;
    logic                             elapsed_pos;
    logic [NW-1:0]                    num_next;
    logic [WW-1:0]                    wide_mag;
    logic [VW-1:0]                    vel_next;
    logic                             out_free;
    logic                             out_load;
    logic                             div_start;
    logic                             cfg_period_wr;

    assign sample_angle = s_tdata[AB-1:0];
    assign in_stamp     = s_tdata[AB+SW-1:AB];

    assign s_tready  = (state_reg == S_IDLE) && !tpm_stale_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = (state_reg == S_OUT) && out_free;

    assign cfg_period_wr = cfg_valid && cfg_ready
                           && (cfg_index == ettv_pkg::REG_COUNTER_PERIOD);

    // The divider is started for ticks per millisecond, for the elapsed time in
    // milliseconds when some time has passed, and for the velocity when at least
    // one whole millisecond has passed.
    assign div_start = ((state_reg == S_IDLE) && tpm_stale_reg)
                       || ((state_reg == S_DT) && elapsed_pos)
                       || ((state_reg == S_VEL) && (dtms_reg != '0));

    // Elapsed ticks. An equal or earlier stamp means the counter wrapped, so a
    // full period is added; a stale stamp beyond the period can make it negative.
    always_comb begin
        if (in_stamp > last_stamp_reg) begin
            elapsed_next = EW'(in_stamp) - EW'(last_stamp_reg);
        end else begin
            elapsed_next = EW'(period_reg) - EW'(last_stamp_reg) + EW'(in_stamp);
        end
    end

    assign elapsed_pos = !elapsed_reg[EW-1] && (elapsed_reg != '0);

    // |dv| * 1000 by shift and subtract: 1000 = 1024 - 16 - 8.
    assign num_next = {turn_res.dv_mag, 10'b0} - NW'({turn_res.dv_mag, 4'b0})
                      - NW'({turn_res.dv_mag, 3'b0});

    // dv * 10000 / (10 * dt_ms) truncates the same as dv * 1000 / dt_ms.
    // With no whole millisecond the divisor is a tenth of one, which is dv * 10000.
    always_comb begin
        if (dtms_reg == '0) begin
            wide_mag = WW'({num_reg, 3'b0}) + WW'({num_reg, 1'b0});
        end else begin
            wide_mag = WW'(div_rsp.quotient);
        end
        if (!turn_res.dv_neg) begin
            vel_next = (wide_mag > POS_LIMIT) ? VEL_MAX : wide_mag[VW-1:0];
        end else begin
            vel_next = (wide_mag > NEG_LIMIT) ? VEL_MIN : -wide_mag[VW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            period_reg        <= PW'(ettv_pkg::RST_COUNTER_PERIOD);
            thr_reg           <= ettv_pkg::THR_W'(ettv_pkg::RST_WRAP_THRESHOLD);
            tpm_reg           <= TW'(ettv_pkg::RST_TPM);
            tpm_stale_reg     <= 1'b0;
            last_stamp_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
            div_req_reg.start <= 1'b0;
        end else begin
            div_req_reg.start <= div_start;
            m_tvalid_reg      <= out_load || (m_tvalid_reg && !m_tready);
            // A period written while the last one is being converted is
            // converted again once the block is back in idle.
            tpm_stale_reg     <= cfg_period_wr || (tpm_stale_reg && (state_reg != S_IDLE));

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ettv_pkg::REG_COUNTER_PERIOD: begin
                        period_reg <= cfg_data;
                    end
                    ettv_pkg::REG_WRAP_THRESHOLD: begin
                        thr_reg <= cfg_data[ettv_pkg::THR_W-1:0];
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (tpm_stale_reg) begin
                        // Ticks per millisecond = period / 1000, recomputed once.
                        div_req_reg.dividend <= {period_reg, {(N - PW){1'b0}}};
                        div_req_reg.divisor  <= D'(ettv_pkg::TICKS_DIV);
                        div_req_reg.steps    <= STW'(PW);
                        state_reg            <= S_TPM;
                    end else if (accept) begin
                        elapsed_reg    <= elapsed_next;
                        last_stamp_reg <= in_stamp;
                        state_reg      <= S_DT;
                    end
                end
                S_TPM: begin
                    if (div_rsp.done) begin
                        // A period below 1000 ticks still counts one tick per ms.
                        if (div_rsp.quotient[TW-1:0] == '0) begin
                            tpm_reg <= TW'(1);
                        end else begin
                            tpm_reg <= div_rsp.quotient[TW-1:0];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_DT: begin
                    if (elapsed_pos) begin
                        div_req_reg.dividend <= {elapsed_reg[DW-1:0], {(N - DW){1'b0}}};
                        div_req_reg.divisor  <= D'(tpm_reg);
                        div_req_reg.steps    <= STW'(DW);
                        state_reg            <= S_DT_WAIT;
                    end else begin
                        dtms_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_DT_WAIT: begin
                    if (div_rsp.done) begin
                        dtms_reg  <= div_rsp.quotient[DW-1:0];
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    num_reg   <= num_next;
                    state_reg <= S_VEL;
                end
                S_VEL: begin
                    if (dtms_reg != '0) begin
                        div_req_reg.dividend <= num_reg;
                        div_req_reg.divisor  <= dtms_reg;
                        div_req_reg.steps    <= STW'(NW);
                        state_reg            <= S_VEL_WAIT;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_VEL_WAIT: begin
                    if (div_rsp.done) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    vel_reg   <= vel_next;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {{(ettv_pkg::M_TDATA_W - ettv_pkg::M_FIELDS_W){1'b0}},
                                         vel_reg, turn_res.rotations, turn_res.position};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ettv_turn #(
        .TURN_BITS (TURN_BITS)
    ) u_turn (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (accept),
        .angle          (sample_angle),
        .wrap_threshold (thr_reg),
        .res            (turn_res)
    );

    ettv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req_reg),
        .rsp     (div_rsp)
    );

endmodule

>>> rtl/ettv_div.sv
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left aligned so that a narrower dividend needs only as many steps as bits.
module ettv_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  ettv_pkg::div_req_t  req,
    output ettv_pkg::div_rsp_t  rsp
);

    logic [ettv_pkg::DIV_D-1:0]  rem_reg;
    logic [ettv_pkg::DIV_N-1:0]  quo_reg;
    logic [ettv_pkg::DIV_D-1:0]  dsr_reg;
    logic [ettv_pkg::DIV_SW-1:0] cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    logic [ettv_pkg::DIV_D:0]    rem_sh;
    logic [ettv_pkg::DIV_D:0]    diff;
    logic                        fits;
    logic                        last_step;

    assign rem_sh    = {rem_reg, quo_reg[ettv_pkg::DIV_N-1]};
    assign diff      = rem_sh - {1'b0, dsr_reg};
    assign fits      = ~diff[ettv_pkg::DIV_D];
    assign last_step = busy_reg && (cnt_reg == ettv_pkg::DIV_SW'(1)) && !req.start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= last_step;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (last_step) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
            cnt_reg <= req.steps;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[ettv_pkg::DIV_D-1:0] : rem_sh[ettv_pkg::DIV_D-1:0];
            quo_reg <= {quo_reg[ettv_pkg::DIV_N-2:0], fits};
            cnt_reg <= cnt_reg - ettv_pkg::DIV_SW'(1);
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

>>> rtl/ettv_turn.sv
// Turn tracker: unwraps the angle into a turn count and forms the position
// and its change since the previous sample.
module ettv_turn #(
    parameter int TURN_BITS = ettv_pkg::TURN_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            step,
    input  logic [ettv_pkg::ANGLE_BITS-1:0] angle,
    input  logic [ettv_pkg::THR_W-1:0]      wrap_threshold,
    output ettv_pkg::turn_res_t             res
);

    localparam int AB = ettv_pkg::ANGLE_BITS;
    localparam int PW = ettv_pkg::POS_W;
    localparam int RW = ettv_pkg::ROT_W;

    logic [AB-1:0]        prev_angle_reg;
    logic [TURN_BITS-1:0] turn_reg;
    logic [PW-1:0]        last_pos_reg;
    ettv_pkg::turn_res_t  res_reg;

    logic [AB:0]          delta;
    logic [AB:0]          delta_abs;
    logic                 crossing;
    logic [TURN_BITS-1:0] turn_next;
    logic [RW-1:0]        rot_out;
    logic [RW-1:0]        rot_pos;
    logic [PW-1:0]        pos_next;
    logic [PW:0]          dv;
    logic [PW:0]          dv_abs;

    // The angle field spans exactly one turn, so it needs no reduction.
    assign delta     = {1'b0, angle} - {1'b0, prev_angle_reg};
    assign delta_abs = delta[AB] ? -delta : delta;
    assign crossing  = delta_abs[AB-1:0] > wrap_threshold;

    always_comb begin
        turn_next = turn_reg;
        if (crossing) begin
            // A forward jump means the sensor crossed zero backwards.
            if (!delta[AB]) begin
                turn_next = turn_reg - TURN_BITS'(1);
            end else begin
                turn_next = turn_reg + TURN_BITS'(1);
            end
        end
    end

    generate
        if (TURN_BITS >= RW) begin : g_wide
            assign rot_out = turn_next[RW-1:0];
            assign rot_pos = turn_next[RW-1:0];
        end else begin : g_narrow
            assign rot_out = {{(RW - TURN_BITS){1'b0}}, turn_next};
            assign rot_pos = {{(RW - TURN_BITS){turn_next[TURN_BITS-1]}}, turn_next};
        end
    endgenerate

    assign pos_next = {rot_pos, angle};
    assign dv       = {pos_next[PW-1], pos_next} - {last_pos_reg[PW-1], last_pos_reg};
    assign dv_abs   = dv[PW] ? -dv : dv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
            turn_reg       <= '0;
            last_pos_reg   <= '0;
        end else if (step) begin
            prev_angle_reg <= angle;
            turn_reg       <= turn_next;
            last_pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg.position  <= pos_next;
            res_reg.rotations <= rot_out;
            res_reg.dv_neg    <= dv[PW];
            res_reg.dv_mag    <= dv_abs[PW-1:0];
        end
    end

    assign res = res_reg;

endmodule
